[rtl/cbpt_pkg.sv]
// cubic bezier point/tangent package: widths, register map, shared types
// no dependencies; imported by every module of the block
`default_nettype none

package cbpt_pkg;

    // coordinate and parameter formats
    localparam int CW       = 21;          // signed Q10.10 coordinate
    localparam int PF       = 16;          // fraction bits of the parameter
    localparam int UW       = PF + 1;      // unsigned Q1.PF parameter
    localparam int TW       = CW + 3;      // tangent width
    localparam int NUM_AXES = 3;
    localparam int PTW      = NUM_AXES * CW;

    // configuration port
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;
    localparam int IDX_LO = 3;             // 8-byte register spacing

    localparam logic [1:0] REG_POINT0 = 2'd0;
    localparam logic [1:0] REG_POINT1 = 2'd1;
    localparam logic [1:0] REG_POINT2 = 2'd2;
    localparam logic [1:0] REG_POINT3 = 2'd3;

    // parameter value of one
    localparam logic [UW-1:0] U_ONE = {1'b1, {PF{1'b0}}};

    typedef logic [PTW-1:0] point_t;
    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [TW-1:0] tan_t;
    typedef logic [UW-1:0] param_t;

    // control points as held by the register block
    typedef struct packed {
        point_t p0;
        point_t p1;
        point_t p2;
        point_t p3;
    } ctrl_pts_t;

endpackage

`default_nettype wire

[rtl/cbpt_lerp.sv]
// one rounded linear step a + u*(b-a), half up, floor toward minus infinity
// depends on cbpt_pkg
`default_nettype none

module cbpt_lerp
    import cbpt_pkg::*;
(
    input  wire coord_t a,
    input  wire coord_t b,
    input  wire param_t u,
    output coord_t      y
);

    localparam int PW = CW + UW + 2;

    logic signed [CW:0]   diff;
    logic signed [UW:0]   u_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shifted;

    // difference and signed product
    assign diff = (CW+1)'(b) - (CW+1)'(a);
    assign u_s  = $signed({1'b0, u});
    assign prod = PW'(diff) * PW'(u_s);

    // round half up, arithmetic shift gives the floor
    assign rnd     = prod + (PW'(1) <<< (PF - 1));
    assign shifted = rnd >>> PF;

    // result stays between a and b, so the low bits are exact
    assign y = a + coord_t'(shifted[CW-1:0]);

endmodule

`default_nettype wire

[rtl/cbpt_cfg.sv]
// control point registers behind an apb-style port
// depends on cbpt_pkg
`default_nettype none

module cbpt_cfg
    import cbpt_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [ADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    output ctrl_pts_t          pts
);

    ctrl_pts_t   pts_reg;
    logic [1:0]  idx;
    logic        wr_en;
    point_t      rd_pt;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:IDX_LO];
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_POINT0: pts_reg.p0 <= pwdata[PTW-1:0];
                REG_POINT1: pts_reg.p1 <= pwdata[PTW-1:0];
                REG_POINT2: pts_reg.p2 <= pwdata[PTW-1:0];
                REG_POINT3: pts_reg.p3 <= pwdata[PTW-1:0];
                default:    pts_reg    <= pts_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (idx)
            REG_POINT0: rd_pt = pts_reg.p0;
            REG_POINT1: rd_pt = pts_reg.p1;
            REG_POINT2: rd_pt = pts_reg.p2;
            REG_POINT3: rd_pt = pts_reg.p3;
            default:    rd_pt = '0;
        endcase
    end

    assign prdata = {{(DATA_W-PTW){1'b0}}, rd_pt};
    assign pts    = pts_reg;

endmodule

`default_nettype wire

[rtl/cubic_bezier_point_tangent.sv]
// cubic bezier point and tangent evaluator, top level
// depends on cbpt_pkg, cbpt_cfg, cbpt_lerp
//
//   channel   direction  handshake                    payload
//   param     in         param_valid / param_stall    param_u
//   result    out        result_valid / result_stall  pos_x..z, tan_x..z
//   config    in         apb write, psel&penable      paddr, pwdata, prdata
//
// four register stages: parameter clamp, first de casteljau level,
// second level, position and tangent. one request per clock sustained
// while result_stall is low; a request passes the stages in that order
// and its result is valid once it reaches the last. each stage holds
// while the stage after it is full and stalled, so bubbles are squeezed out.
// reset clears all stage valid bits and the control points to zero.
`default_nettype none

module cubic_bezier_point_tangent
    import cbpt_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    // parameter channel
    input  wire                param_valid,
    output logic               param_stall,
    input  wire [UW-1:0]       param_u,
    // result channel
    output logic               result_valid,
    input  wire                result_stall,
    output logic signed [CW-1:0] pos_x,
    output logic signed [CW-1:0] pos_y,
    output logic signed [CW-1:0] pos_z,
    output logic signed [TW-1:0] tan_x,
    output logic signed [TW-1:0] tan_y,
    output logic signed [TW-1:0] tan_z,
    // configuration port
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [ADDR_W-1:0]   paddr,
    input  wire [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    ctrl_pts_t pts;
    coord_t    pc [4][NUM_AXES];

    // stage valid bits and payload
    logic   v0_reg, v1_reg, v2_reg, v3_reg;
    logic   en0, en1, en2, en3;
    param_t u0_reg, u1_reg, u2_reg;
    param_t u_sat;
    coord_t q_reg   [NUM_AXES][3];
    coord_t q_next  [NUM_AXES][3];
    coord_t r_reg   [NUM_AXES][2];
    coord_t r_next  [NUM_AXES][2];
    coord_t pos_reg [NUM_AXES];
    coord_t pos_next[NUM_AXES];
    tan_t   tan_reg [NUM_AXES];
    tan_t   tan_next[NUM_AXES];

    cbpt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pts     (pts)
    );

    // unpack control point coordinates
    always_comb
    begin
        for (int ax = 0; ax < NUM_AXES; ax++)
        begin
            pc[0][ax] = pts.p0[ax*CW +: CW];
            pc[1][ax] = pts.p1[ax*CW +: CW];
            pc[2][ax] = pts.p2[ax*CW +: CW];
            pc[3][ax] = pts.p3[ax*CW +: CW];
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    assign en3         = !v3_reg || !result_stall;
    assign en2         = !v2_reg || en3;
    assign en1         = !v1_reg || en2;
    assign en0         = !v0_reg || en1;
    assign param_stall = !en0;

    // clamp the parameter to one
    assign u_sat = (param_u > U_ONE) ? U_ONE : param_u;

    // datapath per axis
    for (genvar ax = 0; ax < NUM_AXES; ax++)
    begin : g_axis
        logic signed [CW:0] rdiff;

        for (genvar k = 0; k < 3; k++)
        begin : g_lvl1
            cbpt_lerp u_lerp (
                .a (pc[k][ax]),
                .b (pc[k+1][ax]),
                .u (u0_reg),
                .y (q_next[ax][k])
            );
        end

        for (genvar k = 0; k < 2; k++)
        begin : g_lvl2
            cbpt_lerp u_lerp (
                .a (q_reg[ax][k]),
                .b (q_reg[ax][k+1]),
                .u (u1_reg),
                .y (r_next[ax][k])
            );
        end

        cbpt_lerp u_lerp3 (
            .a (r_reg[ax][0]),
            .b (r_reg[ax][1]),
            .u (u2_reg),
            .y (pos_next[ax])
        );

        // tangent is three times the last difference
        assign rdiff        = (CW+1)'(r_reg[ax][1]) - (CW+1)'(r_reg[ax][0]);
        assign tan_next[ax] = TW'(rdiff) + (TW'(rdiff) <<< 1);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= param_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            u0_reg <= u_sat;
        end
        if (en1)
        begin
            u1_reg <= u0_reg;
            q_reg  <= q_next;
        end
        if (en2)
        begin
            u2_reg <= u1_reg;
            r_reg  <= r_next;
        end
        if (en3)
        begin
            pos_reg <= pos_next;
            tan_reg <= tan_next;
        end
    end

    // result outputs
    assign result_valid = v3_reg;
    assign pos_x = pos_reg[0];
    assign pos_y = pos_reg[1];
    assign pos_z = pos_reg[2];
    assign tan_x = tan_reg[0];
    assign tan_y = tan_reg[1];
    assign tan_z = tan_reg[2];

    // input is held back only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        param_stall |-> (v0_reg && v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a free pipeline stage");

    // a request taken at the input lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (param_valid && !param_stall) |=> v0_reg)
        else $error("accepted request lost at first stage");

    // a held middle stage keeps its item and parameter
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !en2) |=> (v2_reg && $stable(u2_reg)))
        else $error("held stage changed while blocked");

endmodule

`default_nettype wire
